// File: sv/dsrt_pkg.sv
// dsrt_pkg: shared types, constants, microcode program and packet builder
// for the loco speed table with round-robin refresh. No dependencies.
package dsrt_pkg;

    // fixed field widths
    localparam int ADDR_W  = 14;
    localparam int SPEED_W = 7;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 3;

    // command codes
    localparam logic CMD_SET     = 1'b0;
    localparam logic CMD_REFRESH = 1'b1;

    // packet constants
    localparam logic [SPEED_W-1:0] SPEED_MAX   = 7'd126;
    localparam logic [ADDR_W-1:0]  SHORT_MAX   = 14'd127;
    localparam logic [BYTE_W-1:0]  LONG_PREFIX = 8'hC0;
    localparam logic [BYTE_W-1:0]  SPEED_INSTR = 8'h3F;
    localparam logic [CNT_W-1:0]   CNT_SHORT   = 3'd3;
    localparam logic [CNT_W-1:0]   CNT_LONG    = 3'd4;

    // one table entry as stored in RAM
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [SPEED_W-1:0] speed;
        logic               fwd;
    } t_entry;

    // one result beat
    typedef struct packed {
        logic [BYTE_W-1:0] byte_a;
        logic [BYTE_W-1:0] byte_b;
        logic [BYTE_W-1:0] byte_c;
        logic [BYTE_W-1:0] byte_d;
        logic [CNT_W-1:0]  count;
        logic              full;
    } t_packet;

    // microcode fields
    localparam int PC_W = 3;
    typedef logic [2:0]      t_act;
    typedef logic [2:0]      t_cond;
    typedef logic [PC_W-1:0] t_pc;

    // datapath actions
    localparam t_act A_TAKE   = 3'd0;  // accept an input beat
    localparam t_act A_NONE   = 3'd1;
    localparam t_act A_SCAN   = 3'd2;  // pipelined table scan
    localparam t_act A_COMMIT = 3'd3;  // write entry / move cursor
    localparam t_act A_EMIT   = 3'd4;  // load output register

    // branch conditions
    localparam t_cond C_ACCEPT = 3'd0;  // input taken ? tgt : hold
    localparam t_cond C_SKIP   = 3'd1;  // address zero set ? tgt : next
    localparam t_cond C_SCAN   = 3'd2;  // scan finished ? tgt : hold
    localparam t_cond C_NOHIT  = 3'd3;  // refresh found nothing ? tgt : next
    localparam t_cond C_OUT    = 3'd4;  // output register free ? tgt : hold

    // program steps
    localparam t_pc STEP_IDLE   = 3'd0;
    localparam t_pc STEP_CHK    = 3'd1;
    localparam t_pc STEP_SCAN   = 3'd2;
    localparam t_pc STEP_COMMIT = 3'd3;
    localparam t_pc STEP_EMIT   = 3'd4;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_pc   tgt;
    } t_uword;

    // condition inputs from datapath to sequencer
    typedef struct packed {
        logic accept;
        logic skip;
        logic scan_done;
        logic no_hit;
        logic out_free;
    } t_cond_in;

    // control store
    function automatic t_uword dsrt_ucode(input t_pc pc);
        t_uword w;
        unique case (pc)
            STEP_IDLE:   w = '{act: A_TAKE,   cond: C_ACCEPT, tgt: STEP_CHK};
            STEP_CHK:    w = '{act: A_NONE,   cond: C_SKIP,   tgt: STEP_EMIT};
            STEP_SCAN:   w = '{act: A_SCAN,   cond: C_SCAN,   tgt: STEP_COMMIT};
            STEP_COMMIT: w = '{act: A_COMMIT, cond: C_NOHIT,  tgt: STEP_IDLE};
            STEP_EMIT:   w = '{act: A_EMIT,   cond: C_OUT,    tgt: STEP_IDLE};
            default:     w = '{act: A_NONE,   cond: C_OUT,    tgt: STEP_IDLE};
        endcase
        return w;
    endfunction

    // 128-step speed packet, checksum not included
    function automatic t_packet dsrt_build(input logic [ADDR_W-1:0] addr,
                                           input logic [SPEED_W-1:0] speed,
                                           input logic fwd,
                                           input logic full);
        t_packet p;
        logic [BYTE_W-1:0] sb;
        // speed is at most 126, so speed + 1 fits the low seven bits
        sb = {fwd, speed + SPEED_W'(speed != '0)};
        if (addr > SHORT_MAX) begin
            p.byte_a = {2'b00, addr[ADDR_W-1:BYTE_W]} | LONG_PREFIX;
            p.byte_b = addr[BYTE_W-1:0];
            p.byte_c = SPEED_INSTR;
            p.byte_d = sb;
            p.count  = CNT_LONG;
        end else begin
            p.byte_a = addr[BYTE_W-1:0];
            p.byte_b = SPEED_INSTR;
            p.byte_c = sb;
            p.byte_d = '0;
            p.count  = CNT_SHORT;
        end
        p.full = full;
        return p;
    endfunction

endpackage

// File: sv/dsrt_ram.sv
// dsrt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module dsrt_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/dsrt_seq.sv
// dsrt_seq: step counter and control store of the microcoded sequencer.
// Depends on dsrt_pkg for the control word, codes and program.
module dsrt_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dsrt_pkg::t_cond_in i_cond,
    output dsrt_pkg::t_uword   o_uword
);
    import dsrt_pkg::*;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword uw;

    assign uw      = dsrt_ucode(r_pc);
    assign o_uword = uw;

    // next step: hold, fall through or jump
    always_comb begin
        unique case (uw.cond)
            C_ACCEPT: n_pc = i_cond.accept    ? uw.tgt : r_pc;
            C_SKIP:   n_pc = i_cond.skip      ? uw.tgt : r_pc + t_pc'(1);
            C_SCAN:   n_pc = i_cond.scan_done ? uw.tgt : r_pc;
            C_NOHIT:  n_pc = i_cond.no_hit    ? uw.tgt : r_pc + t_pc'(1);
            C_OUT:    n_pc = i_cond.out_free  ? uw.tgt : r_pc;
            default:  n_pc = STEP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// File: sv/dcc_speed_refresh_table_top.sv
// dcc_speed_refresh_table_top: loco speed table, 128-step packet builder, refresh scan.
// Flow: an address zero set speed goes from accept through the check step straight to the
// emit step; every other beat runs the table scan (one RAM read per cycle, pipelined).
// Throughput: one beat at a time; a new beat is accepted only back in the idle step.
// Reset: synchronous, active low; clears entry valid bits, cursor and control at once,
// no clearing pass. Depends on dsrt_pkg, dsrt_seq, dsrt_ram.
module dcc_speed_refresh_table_top #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_command,
    input  logic [dsrt_pkg::ADDR_W-1:0]      i_loco_address,
    input  logic [dsrt_pkg::SPEED_W-1:0]     i_speed_step,
    input  logic                             i_forward,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [dsrt_pkg::BYTE_W-1:0]      o_packet_byte_a,
    output logic [dsrt_pkg::BYTE_W-1:0]      o_packet_byte_b,
    output logic [dsrt_pkg::BYTE_W-1:0]      o_packet_byte_c,
    output logic [dsrt_pkg::BYTE_W-1:0]      o_packet_byte_d,
    output logic [dsrt_pkg::CNT_W-1:0]       o_byte_count,
    output logic                             o_table_full
);
    import dsrt_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX   = IW'(TABLE_ENTRIES - 1);
    localparam logic [CW-1:0] ISSUE_MAX  = CW'(TABLE_ENTRIES);
    localparam logic [CW-1:0] ISSUE_LAST = CW'(TABLE_ENTRIES - 1);

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] x);
        return (x == LAST_IDX) ? '0 : x + IW'(1);
    endfunction

    t_uword   uw;
    t_cond_in cin;

    // latched beat (refresh reuses it for the found entry)
    logic               r_cmd;
    logic [ADDR_W-1:0]  r_addr;
    logic [SPEED_W-1:0] r_speed;
    logic               r_fwd;
    logic               r_full;

    // scan state
    logic [IW-1:0]            r_idx;
    logic [CW-1:0]            r_issued;
    logic                     r_ev_v;
    logic [IW-1:0]            r_ev_idx;
    logic                     r_ev_last;
    logic                     r_found;
    logic [IW-1:0]            r_hit_idx;
    logic                     r_empty_found;
    logic [IW-1:0]            r_empty_idx;
    logic [IW-1:0]            r_cursor;
    logic [TABLE_ENTRIES-1:0] r_valid;

    // output register
    logic    r_ovalid;
    t_packet r_pkt;

    logic               in_accept;
    logic               can_issue;
    logic               ev_bit;
    logic               ev_hit;
    logic               ev_empty;
    logic               scan_done;
    logic               set_write;
    logic [IW-1:0]      widx;
    logic               out_free;
    logic               out_load;
    logic [SPEED_W-1:0] sat_speed;
    t_entry             ram_rdata;
    t_entry             ram_wdata;
    logic               ram_we;

    dsrt_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cin),
        .o_uword (uw)
    );

    dsrt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (widx),
        .i_wdata (ram_wdata),
        .i_re    (can_issue),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // input handshake
    assign o_stall   = (uw.act != A_TAKE);
    assign in_accept = i_valid && !o_stall;
    assign sat_speed = (i_speed_step > SPEED_MAX) ? SPEED_MAX : i_speed_step;

    // scan: issue one read per cycle, evaluate the entry read last cycle
    assign can_issue = (uw.act == A_SCAN) && (r_issued < ISSUE_MAX);
    assign ev_bit    = r_valid[r_ev_idx];
    assign ev_hit    = r_ev_v && ev_bit &&
                       ((r_cmd == CMD_REFRESH) || (ram_rdata.addr == r_addr));
    assign ev_empty  = r_ev_v && !ev_bit;
    assign scan_done = ev_hit || (r_ev_v && r_ev_last);

    // commit: existing entry first, else first empty one
    assign set_write = (r_cmd == CMD_SET) && (r_found || r_empty_found);
    assign widx      = r_found ? r_hit_idx : r_empty_idx;
    assign ram_we    = (uw.act == A_COMMIT) && set_write;
    assign ram_wdata = '{addr: r_addr, speed: r_speed, fwd: r_fwd};

    // output register frees when its beat is taken
    assign out_free = !r_ovalid || !i_stall;
    assign out_load = (uw.act == A_EMIT) && out_free;

    // sequencer conditions
    assign cin.accept    = in_accept;
    assign cin.skip      = (r_cmd == CMD_SET) && (r_addr == '0);
    assign cin.scan_done = scan_done;
    assign cin.no_hit    = (r_cmd == CMD_REFRESH) && !r_found;
    assign cin.out_free  = out_free;

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_cursor      <= '0;
            r_ovalid      <= 1'b0;
            r_ev_v        <= 1'b0;
            r_found       <= 1'b0;
            r_empty_found <= 1'b0;
            r_issued      <= '0;
            r_idx         <= '0;
        end else begin
            if (in_accept) begin
                r_cmd         <= i_command;
                r_addr        <= i_loco_address;
                r_speed       <= sat_speed;
                r_fwd         <= i_forward;
                r_full        <= 1'b0;
                r_idx         <= (i_command == CMD_REFRESH) ? r_cursor : '0;
                r_issued      <= '0;
                r_ev_v        <= 1'b0;
                r_found       <= 1'b0;
                r_empty_found <= 1'b0;
            end

            if (uw.act == A_SCAN) begin
                r_ev_v    <= can_issue;
                r_ev_idx  <= r_idx;
                r_ev_last <= (r_issued == ISSUE_LAST);
                if (can_issue) begin
                    r_idx    <= wrap_inc(r_idx);
                    r_issued <= r_issued + CW'(1);
                end
                if (ev_hit) begin
                    r_found   <= 1'b1;
                    r_hit_idx <= r_ev_idx;
                    if (r_cmd == CMD_REFRESH) begin
                        r_addr  <= ram_rdata.addr;
                        r_speed <= ram_rdata.speed;
                        r_fwd   <= ram_rdata.fwd;
                    end
                end
                if (ev_empty && !r_empty_found) begin
                    r_empty_found <= 1'b1;
                    r_empty_idx   <= r_ev_idx;
                end
            end

            if (uw.act == A_COMMIT) begin
                if (r_cmd == CMD_SET) begin
                    if (set_write) begin
                        r_valid[widx] <= 1'b1;
                        r_cursor      <= widx;
                    end else begin
                        r_full <= 1'b1;
                    end
                end else begin
                    r_cursor <= r_found ? wrap_inc(r_hit_idx) : '0;
                end
            end

            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_pkt <= dsrt_build(r_addr, r_speed, r_fwd, r_full);
        end
    end

    assign o_valid         = r_ovalid;
    assign o_packet_byte_a = r_pkt.byte_a;
    assign o_packet_byte_b = r_pkt.byte_b;
    assign o_packet_byte_c = r_pkt.byte_c;
    assign o_packet_byte_d = r_pkt.byte_d;
    assign o_byte_count    = r_pkt.count;
    assign o_table_full    = r_pkt.full;

    // cursor stays inside the table
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= LAST_IDX)
        else $error("refresh cursor out of range");

    // a recorded set speed leaves the cursor on a valid entry
    a_commit_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.act == A_COMMIT && set_write) |=> r_valid[r_cursor])
        else $error("committed entry not marked valid");

    // refresh beats never report a full table
    a_refresh_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_cmd == CMD_REFRESH) |-> !r_full)
        else $error("refresh beat flagged table full");

    // scan never issues more reads than entries
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issued <= ISSUE_MAX)
        else $error("scan read count overrun");

endmodule

// File: dv/dcc_speed_refresh_table_top_test.sv
// Self-checking testbench for dcc_speed_refresh_table_top: directed table rows, then random
// set-speed and refresh beats under random sender gaps and receiver stalls.
// Depends on dsrt_pkg and the block RTL.
`timescale 1ns / 100ps

module dcc_speed_refresh_table_top_test;
    import dsrt_pkg::*;

    localparam int TBL_N      = 16;
    localparam int RAND_ITEMS = 1150;
    localparam int CYCLE_MAX  = 400000;
    localparam int HOLD_AT    = 300;   // random item that starts the long receiver hold
    localparam int DRAIN_AT   = 700;   // random item before which the sender waits for drain
    localparam int DIR_N      = 25;

    typedef enum logic [1:0] {EXP_PREDICT, EXP_TYPED, EXP_NOTHING} t_exp_kind;

    typedef struct packed {
        logic               cmd;
        logic [ADDR_W-1:0]  addr;
        logic [SPEED_W-1:0] spd;
        logic               fwd;
        t_exp_kind          kind;
        t_packet            pkt;
    } t_row;

    // directed rows, walked in order from an empty table
    localparam t_row DIRECTED [DIR_N] = '{
        // refresh on empty table: nothing comes out
        '{CMD_REFRESH, 14'd0,     7'd0,   1'b0, EXP_NOTHING, '0},
        // address zero, speed above range saturates
        '{CMD_SET,     14'd0,     7'd127, 1'b1, EXP_TYPED,
          '{8'h00, 8'h3F, 8'hFF, 8'h00, CNT_SHORT, 1'b0}},
        '{CMD_SET,     14'd1,     7'd0,   1'b0, EXP_TYPED,
          '{8'h01, 8'h3F, 8'h00, 8'h00, CNT_SHORT, 1'b0}},
        '{CMD_SET,     14'd127,   7'd126, 1'b1, EXP_TYPED,
          '{8'h7F, 8'h3F, 8'hFF, 8'h00, CNT_SHORT, 1'b0}},
        '{CMD_SET,     14'd128,   7'd1,   1'b0, EXP_TYPED,
          '{8'hC0, 8'h80, 8'h3F, 8'h02, CNT_LONG, 1'b0}},
        '{CMD_SET,     14'd10239, 7'd127, 1'b1, EXP_TYPED,
          '{8'hE7, 8'hFF, 8'h3F, 8'hFF, CNT_LONG, 1'b0}},
        '{CMD_SET,     14'd16383, 7'd127, 1'b0, EXP_TYPED,
          '{8'hFF, 8'hFF, 8'h3F, 8'h7F, CNT_LONG, 1'b0}},
        '{CMD_REFRESH, 14'd0,     7'd0,   1'b0, EXP_PREDICT, '0},
        // refresh ignores the other fields; scan wraps to the first entry
        '{CMD_REFRESH, 14'd16383, 7'd127, 1'b1, EXP_PREDICT, '0},
        '{CMD_SET,     14'd1,     7'd64,  1'b1, EXP_PREDICT, '0},
        '{CMD_REFRESH, 14'd0,     7'd0,   1'b0, EXP_PREDICT, '0},
        // fill the remaining entries
        '{CMD_SET,     14'd2,     7'd10,  1'b0, EXP_PREDICT, '0},
        '{CMD_SET,     14'd42,    7'd33,  1'b1, EXP_PREDICT, '0},
        '{CMD_SET,     14'd85,    7'd100, 1'b0, EXP_PREDICT, '0},
        '{CMD_SET,     14'd100,   7'd126, 1'b1, EXP_PREDICT, '0},
        '{CMD_SET,     14'd126,   7'd5,   1'b0, EXP_PREDICT, '0},
        '{CMD_SET,     14'd129,   7'd77,  1'b1, EXP_PREDICT, '0},
        '{CMD_SET,     14'd255,   7'd0,   1'b1, EXP_PREDICT, '0},
        '{CMD_SET,     14'd256,   7'd127, 1'b0, EXP_PREDICT, '0},
        '{CMD_SET,     14'd1000,  7'd90,  1'b1, EXP_PREDICT, '0},
        '{CMD_SET,     14'd5461,  7'd21,  1'b0, EXP_PREDICT, '0},
        '{CMD_SET,     14'd8191,  7'd60,  1'b1, EXP_PREDICT, '0},
        // table full: packet still goes out, flag set
        '{CMD_SET,     14'd300,   7'd0,   1'b0, EXP_TYPED,
          '{8'hC1, 8'h2C, 8'h3F, 8'h00, CNT_LONG, 1'b1}},
        // last entry refreshed, cursor wraps to zero
        '{CMD_REFRESH, 14'd0,     7'd0,   1'b0, EXP_PREDICT, '0},
        '{CMD_REFRESH, 14'd0,     7'd0,   1'b0, EXP_PREDICT, '0}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_command;
    logic [ADDR_W-1:0]  i_loco_address;
    logic [SPEED_W-1:0] i_speed_step;
    logic               i_forward;
    logic               o_valid;
    logic               i_stall;
    logic [BYTE_W-1:0]  o_packet_byte_a;
    logic [BYTE_W-1:0]  o_packet_byte_b;
    logic [BYTE_W-1:0]  o_packet_byte_c;
    logic [BYTE_W-1:0]  o_packet_byte_d;
    logic [CNT_W-1:0]   o_byte_count;
    logic               o_table_full;

    // speed table mirror
    logic [ADDR_W-1:0]  loco_addr_tbl  [TBL_N];
    logic [SPEED_W-1:0] loco_speed_tbl [TBL_N];
    logic               loco_fwd_tbl   [TBL_N];
    int                 refresh_ptr;

    t_packet pending_packets [$];
    int      err_cnt = 0;
    int      burst_left = 0;
    bit      long_hold_req = 1'b0;

    dcc_speed_refresh_table_top #(.TABLE_ENTRIES(TBL_N)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_loco_address  (i_loco_address),
        .i_speed_step    (i_speed_step),
        .i_forward       (i_forward),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_packet_byte_a (o_packet_byte_a),
        .o_packet_byte_b (o_packet_byte_b),
        .o_packet_byte_c (o_packet_byte_c),
        .o_packet_byte_d (o_packet_byte_d),
        .o_byte_count    (o_byte_count),
        .o_table_full    (o_table_full)
    );

    always #5 i_clk = ~i_clk;

    // 128-step speed packet for one loco
    function automatic t_packet make_packet(input logic [ADDR_W-1:0] a,
                                            input logic [SPEED_W-1:0] s,
                                            input logic f, input logic full);
        t_packet p;
        logic [BYTE_W-1:0] sb;
        sb = 8'(s) + ((s != '0) ? 8'd1 : 8'd0) + (f ? 8'h80 : 8'h00);
        if (a > 14'd127) begin
            p.byte_a = 8'(a >> 8) | LONG_PREFIX;
            p.byte_b = a[7:0];
            p.byte_c = SPEED_INSTR;
            p.byte_d = sb;
            p.count  = CNT_LONG;
        end else begin
            p.byte_a = a[7:0];
            p.byte_b = SPEED_INSTR;
            p.byte_c = sb;
            p.byte_d = '0;
            p.count  = CNT_SHORT;
        end
        p.full = full;
        return p;
    endfunction

    // update the table mirror for one beat; returns 1 when a packet is due
    function automatic bit speed_table_predict(input logic cmd, input logic [ADDR_W-1:0] a,
                                                input logic [SPEED_W-1:0] s_in,
                                                input logic f, output t_packet pkt);
        int slot;
        int free_slot;
        int idx;
        logic [SPEED_W-1:0] s;
        pkt = '0;
        if (cmd == CMD_SET) begin
            s = (s_in > SPEED_MAX) ? SPEED_MAX : s_in;
            slot = -1;
            free_slot = -1;
            if (a != '0) begin
                for (int i = 0; i < TBL_N; i++) begin
                    if (loco_addr_tbl[i] == a) begin
                        slot = i;
                        break;
                    end
                    if (loco_addr_tbl[i] == '0 && free_slot < 0) free_slot = i;
                end
                if (slot < 0) slot = free_slot;
                if (slot >= 0) begin
                    loco_addr_tbl[slot]  = a;
                    loco_speed_tbl[slot] = s;
                    loco_fwd_tbl[slot]   = f;
                    refresh_ptr          = slot;
                end
            end
            pkt = make_packet(a, s, f, (a != '0) && (slot < 0));
            return 1'b1;
        end
        // circular scan from the cursor for an occupied entry
        for (int k = 0; k < TBL_N; k++) begin
            idx = (refresh_ptr + k) % TBL_N;
            if (loco_addr_tbl[idx] != '0) begin
                pkt = make_packet(loco_addr_tbl[idx], loco_speed_tbl[idx],
                                  loco_fwd_tbl[idx], 1'b0);
                refresh_ptr = (idx + 1) % TBL_N;
                return 1'b1;
            end
        end
        refresh_ptr = 0;
        return 1'b0;
    endfunction

    // drive one beat in bursts with random gaps; returns at the accepting edge
    task automatic send_beat(input logic cmd, input logic [ADDR_W-1:0] a,
                             input logic [SPEED_W-1:0] s, input logic f,
                             input t_exp_kind kind, input t_packet typed_pkt);
        int gap;
        t_packet pkt;
        bit due;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 1) == 0) gap = 0;
            else if ($urandom_range(0, 19) == 0) gap = $urandom_range(10, 40);
            else gap = $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_loco_address <= a;
        i_speed_step   <= s;
        i_forward      <= f;
        do @(posedge i_clk); while (o_stall);
        due = speed_table_predict(cmd, a, s, f, pkt);
        case (kind)
            EXP_PREDICT: if (due) pending_packets.push_back(pkt);
            EXP_TYPED:   pending_packets.push_back(typed_pkt);
            default:     ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin : chk_results
        t_packet want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_packets.size() == 0) begin
                $error("packet beat with nothing expected");
                err_cnt++;
            end else begin
                want = pending_packets.pop_front();
                check_field("packet_byte_a", want.byte_a, o_packet_byte_a);
                check_field("packet_byte_b", want.byte_b, o_packet_byte_b);
                check_field("packet_byte_c", want.byte_c, o_packet_byte_c);
                check_field("packet_byte_d", want.byte_d, o_packet_byte_d);
                check_field("byte_count", 8'(want.count), 8'(o_byte_count));
                check_field("table_full", 8'(want.full), 8'(o_table_full));
            end
        end
    end

    // receiver stall pattern, with one long hold on request
    initial begin : rx_stall
        int run_len;
        int hold_left;
        bit hold_taken;
        logic lvl;
        i_stall = 1'b0;
        run_len = 0;
        hold_left = 0;
        hold_taken = 1'b0;
        lvl = 1'b1;
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = 400;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (run_len == 0) begin
                    lvl = ~lvl;
                    if (lvl) run_len = $urandom_range(1, 6);
                    else if ($urandom_range(0, 9) == 0) run_len = $urandom_range(40, 120);
                    else run_len = $urandom_range(1, 12);
                end
                run_len--;
                i_stall <= lvl;
            end
        end
    end

    // watchdog
    initial begin : watchdog
        int cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_MAX) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // stimulus and end of run
    initial begin : stim
        int pick;
        logic [ADDR_W-1:0]  a;
        logic [SPEED_W-1:0] s;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_command      = CMD_SET;
        i_loco_address = '0;
        i_speed_step   = '0;
        i_forward      = 1'b0;
        for (int i = 0; i < TBL_N; i++) begin
            loco_addr_tbl[i]  = '0;
            loco_speed_tbl[i] = '0;
            loco_fwd_tbl[i]   = 1'b0;
        end
        refresh_ptr = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[r])
            send_beat(DIRECTED[r].cmd, DIRECTED[r].addr, DIRECTED[r].spd,
                      DIRECTED[r].fwd, DIRECTED[r].kind, DIRECTED[r].pkt);

        // random mix: mostly hits on known locos, some refreshes, misses and address zero
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == DRAIN_AT) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                while (pending_packets.size() != 0) @(negedge i_clk);
            end
            pick = $urandom_range(0, 99);
            s = ($urandom_range(0, 7) == 0) ? 7'd127 : 7'($urandom_range(0, 126));
            if (pick < 30) begin
                send_beat(CMD_REFRESH, 14'($urandom), 7'($urandom), 1'($urandom),
                          EXP_PREDICT, '0);
            end else begin
                if (pick < 82) a = loco_addr_tbl[$urandom_range(0, TBL_N - 1)];
                else if (pick < 95) a = 14'($urandom_range(1, 16383));
                else a = '0;
                send_beat(CMD_SET, a, s, 1'($urandom), EXP_PREDICT, '0);
            end
            if (n == HOLD_AT) long_hold_req = 1'b1;
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_packets.size() != 0) @(negedge i_clk);
        repeat (TBL_N + 8) @(negedge i_clk);
        if (err_cnt == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
sv/dsrt_pkg.sv
sv/dsrt_ram.sv
sv/dsrt_seq.sv
sv/dcc_speed_refresh_table_top.sv
dv/dcc_speed_refresh_table_top_test.sv
